FILE: sv/uvt_pkg.sv
// Shared types and codes for the unique value table.
// Depends on nothing; imported by uvt_match and unique_value_table.
`default_nettype none

package uvt_pkg;

  // item kinds carried on in_tuser
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // result status codes carried on out_tuser
  localparam logic [2:0] STAT_FOUND     = 3'd0;
  localparam logic [2:0] STAT_INSERTED  = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [2:0] STAT_FULL      = 3'd3;
  localparam logic [2:0] STAT_CLEARED   = 3'd4;

  // fixed port widths
  localparam int unsigned PORT_PART_W  = 32;
  localparam int unsigned PORT_INDEX_W = 8;
  localparam int unsigned PORT_COUNT_W = 9;
  localparam int unsigned TOL_W        = 32;

  // parts whose difference needs more than this many bits never match
  localparam int unsigned NEAR_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } uvt_state_t;

  // status from the compare pipeline back to the sequencer
  typedef struct packed {
    logic hit;   // tagged entry at the end of the pipe matches
    logic busy;  // entries still in flight
  } uvt_match_t;

endpackage

`default_nettype wire

FILE: sv/uvt_store.sv
// Value store: single write port, single read port, registered read data.
// Depends on nothing outside this file.
`default_nettype none

module uvt_store #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 64
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/uvt_match.sv
// Compare pipeline: squared distance of a stored entry to the query, two stages.
// Depends on uvt_pkg.
`default_nettype none

module uvt_match
  import uvt_pkg::*;
#(
  parameter int unsigned PART_W = 32,
  parameter int unsigned TAG_W  = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                flush,
  input  wire logic                ent_vld,
  input  wire logic [TAG_W-1:0]    ent_tag,
  input  wire logic [2*PART_W-1:0] ent_data,
  input  wire logic [PART_W-1:0]   q_re,
  input  wire logic [PART_W-1:0]   q_im,
  input  wire logic [TOL_W-1:0]    tol,
  output uvt_match_t               res,
  output logic      [TAG_W-1:0]    hit_tag
);

  localparam int unsigned DIFF_W = PART_W + 1;
  localparam int unsigned WIDE_W = 2 * NEAR_W + 1;

  logic signed [DIFF_W-1:0] d_re, d_im;
  logic        [DIFF_W-1:0] m_re, m_im;
  logic        [WIDE_W-1:0] w_re, w_im;

  logic                     a_vld_r;
  logic        [TAG_W-1:0]  a_tag_r;
  logic                     a_far_r;
  logic        [NEAR_W-1:0] a_re_r, a_im_r;

  logic                      b_vld_r;
  logic        [TAG_W-1:0]   b_tag_r;
  logic                      b_far_r;
  logic        [2*NEAR_W-1:0] b_re_r, b_im_r;

  logic        [WIDE_W-1:0] sq_sum;

  // part differences and magnitudes, sign-extended by one bit
  always_comb begin
    d_re = $signed({ent_data[PART_W-1], ent_data[PART_W-1:0]})
         - $signed({q_re[PART_W-1], q_re});
    d_im = $signed({ent_data[2*PART_W-1], ent_data[2*PART_W-1:PART_W]})
         - $signed({q_im[PART_W-1], q_im});
    m_re = d_re[DIFF_W-1] ? DIFF_W'(-d_re) : DIFF_W'(d_re);
    m_im = d_im[DIFF_W-1] ? DIFF_W'(-d_im) : DIFF_W'(d_im);
    w_re = WIDE_W'(m_re);
    w_im = WIDE_W'(m_im);
  end

  // stage A: magnitudes and the too-far flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= ent_vld && !flush;
    end
  end

  always_ff @(posedge clk) begin
    a_tag_r <= ent_tag;
    a_far_r <= (|w_re[WIDE_W-1:NEAR_W]) || (|w_im[WIDE_W-1:NEAR_W]);
    a_re_r  <= w_re[NEAR_W-1:0];
    a_im_r  <= w_im[NEAR_W-1:0];
  end

  // stage B: squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r && !flush;
    end
  end

  always_ff @(posedge clk) begin
    b_tag_r <= a_tag_r;
    b_far_r <= a_far_r;
    b_re_r  <= a_re_r * a_re_r;
    b_im_r  <= a_im_r * a_im_r;
  end

  // sum and tolerance check
  always_comb begin
    sq_sum   = WIDE_W'(b_re_r) + WIDE_W'(b_im_r);
    res.hit  = b_vld_r && !b_far_r && (sq_sum <= WIDE_W'(tol));
    res.busy = a_vld_r || b_vld_r;
    hit_tag  = b_tag_r;
  end

endmodule

`default_nettype wire

FILE: sv/unique_value_table.sv
// Unique value table: insert-or-find over a store of distinct complex values.
// A clear goes straight to the output register; a lookup scans the filled entries, reading
// one entry a cycle, through store read, stage A and stage B, and stops at the first match.
// One item at a time: the next item is taken the cycle after the result is loaded into
// the output register; a held result stalls.
// Reset (rst_n, synchronous) empties the table and sets the tolerance to 0.
`default_nettype none

module unique_value_table
  import uvt_pkg::*;
#(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned PART_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] value_re, [63:32] value_im
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // [7:0] entry_index, [16:8] entry_count, zero pad
  output logic      [2:0]  out_tuser,  // [2:0] status
  // tolerance register
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned ENT_W = 2 * PART_WIDTH;

  uvt_state_t state_r, state_nxt;

  logic [TOL_W-1:0]      tol_r;
  logic [1:0]            kind_r;
  logic [PART_WIDTH-1:0] q_re_r, q_im_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      scan_r, scan_nxt;
  logic [CNT_W-1:0]      res_idx_r, res_idx_nxt;
  logic [2:0]            res_stat_r, res_stat_nxt;
  logic                  rd_vld_r;
  logic [IDX_W-1:0]      rd_tag_r;

  logic                  out_tvalid_r;
  logic [PORT_INDEX_W-1:0] out_idx_r;
  logic [PORT_COUNT_W-1:0] out_cnt_r;
  logic [2:0]            out_stat_r;

  logic                  in_accept;
  logic                  rd_en, wr_en, flush, out_load;
  logic [ENT_W-1:0]      rd_data;
  uvt_match_t            mres;
  logic [IDX_W-1:0]      hit_tag;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  uvt_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W),
    .DATA_W (ENT_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data ({q_im_r, q_re_r}),
    .rd_en   (rd_en),
    .rd_addr (scan_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  uvt_match #(
    .PART_W (PART_WIDTH),
    .TAG_W  (IDX_W)
  ) u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .flush    (flush),
    .ent_vld  (rd_vld_r),
    .ent_tag  (rd_tag_r),
    .ent_data (rd_data),
    .q_re     (q_re_r),
    .q_im     (q_im_r),
    .tol      (tol_r),
    .res      (mres),
    .hit_tag  (hit_tag)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state, scan issue and result decision
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    scan_nxt     = scan_r;
    res_idx_nxt  = res_idx_r;
    res_stat_nxt = res_stat_r;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    flush        = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_tuser == KIND_CLEAR) begin
            cnt_nxt      = '0;
            res_idx_nxt  = '0;
            res_stat_nxt = STAT_CLEARED;
            state_nxt    = ST_DONE;
          end else begin
            scan_nxt  = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (mres.hit) begin
          // first match in index order wins; drop what is in flight
          flush        = 1'b1;
          res_idx_nxt  = CNT_W'(hit_tag);
          res_stat_nxt = STAT_FOUND;
          state_nxt    = ST_DONE;
        end else if (scan_r < cnt_r) begin
          rd_en    = 1'b1;
          scan_nxt = scan_r + 1'b1;
        end else if (!rd_vld_r && !mres.busy) begin
          // every filled entry checked, none matched
          state_nxt = ST_DONE;
          if (kind_r != KIND_INSERT) begin
            res_idx_nxt  = '0;
            res_stat_nxt = STAT_NOT_FOUND;
          end else if (cnt_r == CNT_W'(CAPACITY)) begin
            res_idx_nxt  = '0;
            res_stat_nxt = STAT_FULL;
          end else begin
            wr_en        = 1'b1;
            res_idx_nxt  = cnt_r;
            res_stat_nxt = STAT_INSERTED;
            cnt_nxt      = cnt_r + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // fill count and read-valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      rd_vld_r <= rd_en;
    end
  end

  // item and scan payload
  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    res_idx_r  <= res_idx_nxt;
    res_stat_r <= res_stat_nxt;
    if (rd_en) begin
      rd_tag_r <= scan_r[IDX_W-1:0];
    end
    if (in_accept) begin
      kind_r <= in_tuser;
      q_re_r <= in_tdata[PART_WIDTH-1:0];
      q_im_r <= in_tdata[PORT_PART_W+PART_WIDTH-1:PORT_PART_W];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r  <= PORT_INDEX_W'(res_idx_r);
      out_cnt_r  <= PORT_COUNT_W'(cnt_r);
      out_stat_r <= res_stat_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_cnt_r, out_idx_r};
  assign out_tuser  = out_stat_r;

endmodule

`default_nettype wire
